FILE: hw/rtl/bitmap_allocator_unit_macros.svh
// Assertion macros for the bitmap allocator unit.
`ifndef BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BMA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bma_pkg.sv
// Shared types and constants for the bitmap allocator unit.
package bma_pkg;

    localparam int CMD_W         = 2;
    localparam int IDX_W         = 10;
    localparam int LEN_W         = 11;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 24;
    localparam int MAP_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 64;
    localparam int DIV_SHIFT     = 17;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
    localparam logic [LEN_W-1:0] COUNT_MAX = 11'd2047;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_UPDATE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic decode;
        logic fetch;
        logic update;
        logic scan;
        logic emit;
    } bma_ctrl_t;

    typedef struct packed {
        logic clear_last;
        logic go_fetch;
        logic go_scan;
        logic scan_stop;
    } bma_stat_t;

endpackage

FILE: hw/rtl/bitmap_allocator_unit.sv
// Top level of the bitmap allocator unit: stream ports, output register, assertions.
// Read and write within the length pass from acceptance through decode, fetch and update to
// done; an index out of range or the unused command goes from decode straight to done;
// allocate scans the map word by word through the single read port of the map memory. One
// transaction is in work at a time; the output register frees the input.
// Reset clears the map one word per cycle (MAP_BITS / WORD_BITS words, rounded up); no input then.
`include "bitmap_allocator_unit_macros.svh"

module bitmap_allocator_unit #(
    parameter int MAP_BITS  = bma_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = bma_pkg::WORD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bma_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd[1:0], bit_index[11:2], bit_value[12], zero[15:13]
    input  logic [bma_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bit_out[0], alloc_index[10:1], alloc_ok[11], range_error[12], set_count[23:13]
    output logic [bma_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import bma_pkg::*;

    bma_ctrl_t             ctrl_cmd;
    bma_stat_t             dp_stat;
    logic                  out_free;
    logic                  res_bit_out;
    logic [IDX_W-1:0]      res_alloc_index;
    logic                  res_alloc_ok;
    logic                  res_range_error;
    logic [LEN_W-1:0]      res_set_count;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    bma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (dp_stat),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .in_ready (s_tready),
        .ctrl     (ctrl_cmd)
    );

    bma_dp #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl_cmd),
        .stat            (dp_stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_cmd          (s_tdata[1:0]),
        .in_index        (s_tdata[11:2]),
        .in_value        (s_tdata[12]),
        .res_bit_out     (res_bit_out),
        .res_alloc_index (res_alloc_index),
        .res_alloc_ok    (res_alloc_ok),
        .res_range_error (res_range_error),
        .res_set_count   (res_set_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl_cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.emit) begin
            m_tdata_reg <= {res_set_count, res_range_error, res_alloc_ok,
                            res_alloc_index, res_bit_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BMA_ASSERT_SAME(a_emit_free, aclk, aresetn, ctrl_cmd.emit, out_free, "result over pending")
    `BMA_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_tvalid && s_tready, !s_tready, "double take")
    `BMA_ASSERT_SAME(a_flags_excl, aclk, aresetn, m_tvalid && m_tdata[11], !m_tdata[12], "flags")
    `BMA_ASSERT_NEXT(a_out_drain, aclk, aresetn, m_tvalid && m_tready && !ctrl_cmd.emit, !m_tvalid, "rep")

endmodule

FILE: hw/rtl/bma_ctrl.sv
// Control state machine of the bitmap allocator unit.
module bma_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  bma_pkg::bma_stat_t  stat,
    input  logic                in_valid,
    input  logic                out_free,
    output logic                in_ready,
    output bma_pkg::bma_ctrl_t  ctrl
);
    import bma_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ctrl.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                ctrl.decode = 1'b1;
                if (stat.go_fetch) begin
                    state_next = ST_FETCH;
                end else if (stat.go_scan) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FETCH: begin
                ctrl.fetch = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                ctrl.update = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN: begin
                ctrl.scan = 1'b1;
                if (stat.scan_stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ctrl.emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bma_dp.sv
// Datapath of the bitmap allocator unit: map memory, word scan and set-bit count.
module bma_dp #(
    parameter int MAP_BITS  = bma_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = bma_pkg::WORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bma_pkg::bma_ctrl_t          ctrl,
    output bma_pkg::bma_stat_t          stat,
    input  logic                        cfg_wr_en,
    input  logic [bma_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic [bma_pkg::CMD_W-1:0]   in_cmd,
    input  logic [bma_pkg::IDX_W-1:0]   in_index,
    input  logic                        in_value,
    output logic                        res_bit_out,
    output logic [bma_pkg::IDX_W-1:0]   res_alloc_index,
    output logic                        res_alloc_ok,
    output logic                        res_range_error,
    output logic [bma_pkg::LEN_W-1:0]   res_set_count
);
    import bma_pkg::*;

    localparam int NWORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CTR_W   = $clog2(NWORDS + 1);
    localparam int OFS_W   = $clog2(WORD_BITS);
    localparam int SPAN    = NWORDS * WORD_BITS;
    localparam int POS_W   = $clog2(SPAN + WORD_BITS + 1);
    localparam int CNT_W   = $clog2(MAP_BITS + 1);
    localparam int CMP_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int SAT_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int RECIP   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = IDX_W + RECIP_W;

    logic [WORD_BITS-1:0] mem [NWORDS];

    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 val_reg;
    logic [LEN_W-1:0]     len_cfg_reg;
    logic [IDX_W-1:0]     word_reg;
    logic [OFS_W-1:0]     ofs_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [ADDR_W-1:0]    clr_ptr_reg;
    logic [CTR_W-1:0]     issue_ptr_reg;
    logic [CMP_W-1:0]     issue_base_reg;
    logic                 pend_reg;
    logic [ADDR_W-1:0]    pend_addr_reg;
    logic [CMP_W-1:0]     pend_base_reg;

    logic [CMP_W-1:0]     len_ext;
    logic [CMP_W-1:0]     len_used;
    logic                 in_range;
    logic                 is_rw;
    logic [PROD_W-1:0]    quot_prod;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 prev_bit;
    logic [WORD_BITS-1:0] upd_word;
    logic                 zfound;
    logic [OFS_W-1:0]     zpos;
    logic [WORD_BITS-1:0] alloc_word;
    logic [CMP_W-1:0]     hit_pos;
    logic                 hit;
    logic                 issue_ok;
    logic [SAT_W-1:0]     count_ext;

    // Effective length and range check.
    always_comb begin
        len_ext   = CMP_W'(len_cfg_reg);
        len_used  = (len_ext > CMP_W'(MAP_BITS)) ? CMP_W'(MAP_BITS) : len_ext;
        in_range  = CMP_W'(idx_reg) < len_used;
        is_rw     = (cmd_reg == CMD_READ) || (cmd_reg == CMD_WRITE);
        quot_prod = PROD_W'(idx_reg) * PROD_W'(RECIP);
    end

    // Bit update for read and write.
    always_comb begin
        prev_bit          = rdata_reg[ofs_reg];
        upd_word          = rdata_reg;
        upd_word[ofs_reg] = val_reg;
    end

    // Lowest clear bit of the word under scan.
    always_comb begin
        zfound = 1'b0;
        zpos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rdata_reg[i]) begin
                zfound = 1'b1;
                zpos   = OFS_W'(i);
            end
        end
        alloc_word       = rdata_reg;
        alloc_word[zpos] = 1'b1;
        hit_pos          = pend_base_reg + CMP_W'(zpos);
        hit              = pend_reg && zfound && (hit_pos < len_used);
        issue_ok         = issue_ptr_reg < CTR_W'(NWORDS);
    end

    always_comb begin
        stat.clear_last = clr_ptr_reg == ADDR_W'(NWORDS - 1);
        stat.go_fetch   = is_rw && in_range;
        stat.go_scan    = cmd_reg == CMD_ALLOC;
        stat.scan_stop  = pend_reg &&
                          (zfound || ((pend_base_reg + CMP_W'(WORD_BITS)) >= len_used));
    end

    // Memory port selection.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(word_reg);
        wr_en   = 1'b0;
        wr_addr = clr_ptr_reg;
        wr_data = '0;
        if (ctrl.fetch) begin
            rd_en = 1'b1;
        end
        if (ctrl.scan && issue_ok) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(issue_ptr_reg);
        end
        if (ctrl.clear) begin
            wr_en = 1'b1;
        end
        if (ctrl.update && (cmd_reg == CMD_WRITE) && (prev_bit != val_reg)) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(word_reg);
            wr_data = upd_word;
        end
        if (ctrl.scan && hit) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = alloc_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Running set-bit count.
    always_comb begin
        count_next = count_reg;
        if (ctrl.update && (cmd_reg == CMD_WRITE) && (prev_bit != val_reg)) begin
            count_next = val_reg ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
        end
        if (ctrl.scan && hit) begin
            count_next = count_reg + CNT_W'(1);
        end
        count_ext     = SAT_W'(count_reg);
        res_set_count = (count_ext > SAT_W'(COUNT_MAX)) ? COUNT_MAX : LEN_W'(count_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_cfg_reg <= LEN_RESET;
            count_reg   <= '0;
            clr_ptr_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                len_cfg_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (ctrl.clear) begin
                clr_ptr_reg <= clr_ptr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_NONE;
            pend_reg      <= 1'b0;
            issue_ptr_reg <= '0;
        end else begin
            if (ctrl.load) begin
                cmd_reg <= cmd_t'(in_cmd);
            end
            if (ctrl.decode) begin
                pend_reg      <= 1'b0;
                issue_ptr_reg <= '0;
            end else if (ctrl.scan) begin
                pend_reg <= issue_ok;
                if (issue_ok) begin
                    issue_ptr_reg <= issue_ptr_reg + CTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            idx_reg <= in_index;
            val_reg <= in_value;
        end
        if (ctrl.decode) begin
            word_reg        <= IDX_W'(quot_prod >> DIV_SHIFT);
            issue_base_reg  <= '0;
            res_bit_out     <= 1'b0;
            res_alloc_index <= '0;
            res_alloc_ok    <= 1'b0;
            res_range_error <= is_rw && !in_range;
        end
        if (ctrl.fetch) begin
            ofs_reg <= OFS_W'(idx_reg - IDX_W'(word_reg * WORD_BITS));
        end
        if (ctrl.update) begin
            res_bit_out <= prev_bit;
        end
        if (ctrl.scan) begin
            pend_addr_reg  <= ADDR_W'(issue_ptr_reg);
            pend_base_reg  <= issue_base_reg;
            issue_base_reg <= issue_base_reg + CMP_W'(WORD_BITS);
            if (hit) begin
                res_alloc_ok    <= 1'b1;
                res_alloc_index <= IDX_W'(hit_pos);
            end
        end
    end

endmodule
